// File: hdl/sqr_pkg.sv
// Shared types, character codes and scanner functions for the quote rewriter.
`timescale 1ns / 1ps

package sqr_pkg;

    // Sizes of the per-request expansion buffer and the datum depth counter.
    localparam int MaxResults = 9;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int IdxW       = $clog2(MaxResults);
    localparam int MaxDepth   = 255;
    localparam int DepthW     = $clog2(MaxDepth + 1);

    // Character codes that the scanner reacts to.
    localparam logic [7:0] ChHash    = 8'h23;
    localparam logic [7:0] ChOpen    = 8'h28;
    localparam logic [7:0] ChClose   = 8'h29;
    localparam logic [7:0] ChSemi    = 8'h3B;
    localparam logic [7:0] ChDquote  = 8'h22;
    localparam logic [7:0] ChQuote   = 8'h27;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChCr      = 8'h0D;

    // Fixed expansion texts: "(quote " and "(vector ".
    localparam int QuoteLen  = 7;
    localparam int VectorLen = 8;
    localparam logic [7:0] QuoteText [QuoteLen] =
        '{8'h28, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h65, 8'h20};
    localparam logic [7:0] VectorText [VectorLen] =
        '{8'h28, 8'h76, 8'h65, 8'h63, 8'h74, 8'h6F, 8'h72, 8'h20};

    // Scanner mode, one-hot.
    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_STRING  = 4'b0100,
        MODE_QUOTE   = 4'b1000
    } t_mode;

    // Bytes released by one request, plus whether the request closed the text.
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [CountW-1:0]          count;
        logic                       last;
    } t_emit;

    // Scanner state travelling together with the bytes it has produced so far.
    typedef struct packed {
        t_mode             mode;
        logic [DepthW-1:0] depth;
        t_emit             emit;
    } t_scan;

    // Append one byte to an expansion, dropping anything beyond the buffer.
    function automatic t_emit f_put(t_emit e, logic [7:0] b);
        t_emit r;
        r = e;
        if (e.count < CountW'(MaxResults)) begin
            r.bytes[e.count[IdxW-1:0]] = b;
            r.count = e.count + CountW'(1);
        end
        return r;
    endfunction

    // Whitespace is tab to carriage return, and space.
    function automatic logic f_is_ws(logic [7:0] c);
        return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    endfunction

    // One scanner step on one byte of the expanded text.
    function automatic t_scan f_scan(t_scan s, logic [7:0] c);
        t_scan r;
        r = s;
        case (s.mode)
            MODE_NORMAL: begin
                if (c == ChSemi) begin
                    r.emit = f_put(r.emit, c);
                    r.mode = MODE_COMMENT;
                end else if (c == ChDquote) begin
                    r.emit = f_put(r.emit, c);
                    r.mode = MODE_STRING;
                end else if (c == ChQuote) begin
                    for (int k = 0; k < QuoteLen; k++) begin
                        r.emit = f_put(r.emit, QuoteText[k]);
                    end
                    r.depth = '0;
                    r.mode  = MODE_QUOTE;
                end else begin
                    r.emit = f_put(r.emit, c);
                end
            end
            MODE_COMMENT: begin
                r.emit = f_put(r.emit, c);
                if (c == ChNewline) begin
                    r.mode = MODE_NORMAL;
                end
            end
            MODE_STRING: begin
                r.emit = f_put(r.emit, c);
                if (c == ChDquote) begin
                    r.mode = MODE_NORMAL;
                end
            end
            MODE_QUOTE: begin
                if (c == ChOpen) begin
                    r.emit = f_put(r.emit, c);
                    if (s.depth < DepthW'(MaxDepth)) begin
                        r.depth = s.depth + DepthW'(1);
                    end
                end else if (c == ChClose) begin
                    r.emit = f_put(r.emit, c);
                    if (s.depth != '0) begin
                        r.depth = s.depth - DepthW'(1);
                    end else begin
                        r.emit = f_put(r.emit, ChClose);
                        r.mode = MODE_NORMAL;
                    end
                end else if (f_is_ws(c) && (s.depth == '0)) begin
                    r.emit = f_put(r.emit, ChClose);
                    r.mode = MODE_NORMAL;
                end else begin
                    r.emit = f_put(r.emit, c);
                end
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hdl/sqr_scan.sv
// Scanner state and the single-pass expansion of one source byte.
`timescale 1ns / 1ps

module sqr_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_in_byte,
    input  logic                i_end_of_text,
    output sqr_pkg::t_emit      o_emit
);

    sqr_pkg::t_mode                  r_mode;
    logic [sqr_pkg::DepthW-1:0]      r_depth;
    logic                            r_hash;

    sqr_pkg::t_mode                  n_mode;
    logic [sqr_pkg::DepthW-1:0]      n_depth;
    logic                            n_hash;

    sqr_pkg::t_scan                  s;

    // Expand the current byte: "#(" handling, the scanner, then end-of-text closing.
    always_comb begin
        s.mode  = r_mode;
        s.depth = r_depth;
        s.emit  = '0;
        n_hash  = r_hash;

        if (r_hash && (i_in_byte == sqr_pkg::ChOpen)) begin
            // "(vector " holds no special byte; only its opening bracket counts in a datum.
            n_hash = 1'b0;
            for (int k = 0; k < sqr_pkg::VectorLen; k++) begin
                s.emit = sqr_pkg::f_put(s.emit, sqr_pkg::VectorText[k]);
            end
            if ((s.mode == sqr_pkg::MODE_QUOTE) &&
                (s.depth < sqr_pkg::DepthW'(sqr_pkg::MaxDepth))) begin
                s.depth = s.depth + sqr_pkg::DepthW'(1);
            end
        end else begin
            if (r_hash) begin
                n_hash = 1'b0;
                s = sqr_pkg::f_scan(s, sqr_pkg::ChHash);
            end
            if (i_in_byte == sqr_pkg::ChHash) begin
                n_hash = 1'b1;
            end else begin
                s = sqr_pkg::f_scan(s, i_in_byte);
            end
        end

        n_mode  = s.mode;
        n_depth = s.depth;

        if (i_end_of_text) begin
            // Release a held hash, close an open datum and start afresh.
            if (n_hash) begin
                s = sqr_pkg::f_scan(s, sqr_pkg::ChHash);
            end
            if (s.mode == sqr_pkg::MODE_QUOTE) begin
                s.emit = sqr_pkg::f_put(s.emit, sqr_pkg::ChClose);
            end
            s.emit.last = 1'b1;
            n_mode  = sqr_pkg::MODE_NORMAL;
            n_depth = '0;
            n_hash  = 1'b0;
        end
    end

    assign o_emit = s.emit;

    // State advances only when a request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sqr_pkg::MODE_NORMAL;
            r_depth <= '0;
            r_hash  <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_hash  <= n_hash;
        end
    end

    // A non-zero depth only exists inside a quoted datum.
    a_depth_in_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) |-> (r_mode == sqr_pkg::MODE_QUOTE))
        else $error("depth non-zero outside a quoted datum");

endmodule

// File: hdl/sqr_emit.sv
// Result register that holds one request's expansion and releases it a byte at a time.
`timescale 1ns / 1ps

module sqr_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  sqr_pkg::t_emit  i_emit,
    output logic            o_can_load,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);

    logic [sqr_pkg::MaxResults-1:0][7:0] r_bytes;
    logic [sqr_pkg::CountW-1:0]          r_count;
    logic                                r_last;
    logic                                take;

    // The head byte goes out; a new expansion may enter as the final byte leaves.
    assign o_out_valid = (r_count != '0);
    assign o_out_byte  = r_bytes[0];
    assign o_last      = r_last && (r_count == sqr_pkg::CountW'(1));
    assign take        = o_out_valid && i_out_ready;
    assign o_can_load  = (r_count == '0) ||
                         ((r_count == sqr_pkg::CountW'(1)) && i_out_ready);

    // Byte buffer shifts down by one byte per delivered result.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_emit.bytes;
        end else if (take) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    // Remaining count and the end-of-text flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= 1'b0;
        end else if (i_load) begin
            r_count <= i_emit.count;
            r_last  <= i_emit.last;
        end else if (take) begin
            r_count <= r_count - sqr_pkg::CountW'(1);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sqr_pkg::CountW'(sqr_pkg::MaxResults))
        else $error("expansion count beyond buffer size");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (r_count == sqr_pkg::CountW'(1)))
        else $error("last flag on a byte that is not the final one");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && (i_emit.count != '0)) |=> (o_out_valid && (r_count == $past(i_emit.count))))
        else $error("loaded expansion not presented");

endmodule

// File: hdl/scheme_quote_rewriter.sv
// Top level of the streaming Scheme quote and vector rewriter.
`timescale 1ns / 1ps

// Takes Scheme source one byte per request and delivers the rewritten text one
// byte per request: "#(" becomes "(vector ", a quote mark becomes "(quote "
// followed by the datum and a closing bracket, and comments and strings pass
// unchanged but for "#(". A byte that expands to n output bytes (0 to 9) holds
// the input until the last of them is taken, when the next request enters; the
// buffer drains one byte per cycle while i_out_ready is high, so plain text flows
// at one byte per cycle, each byte out in the cycle after it is taken. A '#' is
// held back until the following byte arrives, so it appears one request later.
// The final byte of a text carries o_last; the block then returns to reset state.
module scheme_quote_rewriter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    sqr_pkg::t_emit emit;
    logic           can_load;
    logic           accept;

    // A request is taken whenever the result buffer is free or about to empty.
    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    sqr_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_emit        (emit)
    );

    sqr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_emit      (emit),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// File: tb/sv/scheme_quote_rewriter_test.sv
// Self-checking testbench for the streaming Scheme quote and vector rewriter.
`timescale 1ns / 1ps

module scheme_quote_rewriter_test;

    import sqr_pkg::*;

    localparam string QuoteWord  = "(quote ";
    localparam string VectorWord = "(vector ";
    localparam int    IdleLimit  = 2000;
    localparam int    LongHold   = 300;
    localparam int    RandomItems = 210;

    // Rewriting predictor and the queue of rewritten bytes still awaited.
    class rewrite_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } rewritten_t;

        t_mode             mode;
        logic [DepthW-1:0] depth;
        bit                hash_held;
        rewritten_t        expected_bytes[$];
        rewritten_t        step_bytes[$];
        int                errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode      = MODE_NORMAL;
            depth     = '0;
            hash_held = 1'b0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // One request never releases more than the buffer holds.
        function void put(logic [7:0] c);
            rewritten_t r;
            r.ch   = c;
            r.last = 1'b0;
            if (step_bytes.size() < MaxResults) begin
                step_bytes.push_back(r);
            end
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
        endfunction

        // Scanner over the text after vector expansion.
        function void scan_char(logic [7:0] c);
            case (mode)
                MODE_NORMAL: begin
                    if (c == ChSemi) begin
                        put(c);
                        mode = MODE_COMMENT;
                    end else if (c == ChDquote) begin
                        put(c);
                        mode = MODE_STRING;
                    end else if (c == ChQuote) begin
                        for (int i = 0; i < QuoteWord.len(); i++) begin
                            put(QuoteWord[i]);
                        end
                        depth = '0;
                        mode  = MODE_QUOTE;
                    end else begin
                        put(c);
                    end
                end
                MODE_COMMENT: begin
                    put(c);
                    if (c == ChNewline) begin
                        mode = MODE_NORMAL;
                    end
                end
                MODE_STRING: begin
                    put(c);
                    if (c == ChDquote) begin
                        mode = MODE_NORMAL;
                    end
                end
                default: begin
                    if (c == ChOpen) begin
                        put(c);
                        if (depth < DepthW'(MaxDepth)) begin
                            depth = depth + 1'b1;
                        end
                    end else if (c == ChClose) begin
                        put(c);
                        if (depth != '0) begin
                            depth = depth - 1'b1;
                        end else begin
                            put(ChClose);
                            mode = MODE_NORMAL;
                        end
                    end else if (is_blank(c) && (depth == '0)) begin
                        put(ChClose);
                        mode = MODE_NORMAL;
                    end else begin
                        put(c);
                    end
                end
            endcase
        endfunction

        // Works out the bytes that one accepted source byte releases.
        function void note_source_byte(logic [7:0] c, logic eot);
            step_bytes.delete();
            if (hash_held && (c == ChOpen)) begin
                hash_held = 1'b0;
                for (int i = 0; i < VectorWord.len(); i++) begin
                    scan_char(VectorWord[i]);
                end
            end else begin
                if (hash_held) begin
                    hash_held = 1'b0;
                    scan_char(ChHash);
                end
                if (c == ChHash) begin
                    hash_held = 1'b1;
                end else begin
                    scan_char(c);
                end
            end
            // End of text flushes a held hash, closes an open datum and resets.
            if (eot) begin
                if (hash_held) begin
                    hash_held = 1'b0;
                    scan_char(ChHash);
                end
                if (mode == MODE_QUOTE) begin
                    put(ChClose);
                end
                if (step_bytes.size() > 0) begin
                    step_bytes[step_bytes.size() - 1].last = 1'b1;
                end
                clear_state();
            end
            foreach (step_bytes[i]) begin
                expected_bytes.push_back(step_bytes[i]);
            end
        endfunction

        function void check_rewritten_byte(logic [7:0] c, logic last);
            rewritten_t e;
            if (expected_bytes.size() == 0) begin
                $error("out_byte: got 0x%02h with nothing expected", c);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (c !== e.ch) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", e.ch, c);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last;

    rewrite_scoreboard sb;
    int         idle_cycles = 0;
    int         burst_left  = 0;
    int         items_sent  = 0;
    bit         long_hold_req = 1'b0;
    logic [7:0] text_q[$];

    scheme_quote_rewriter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Both handshakes are observed at the edge on which they complete.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_source_byte(i_in_byte, i_end_of_text);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_rewritten_byte(o_out_byte, o_last);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: rotating stall patterns, plus one long hold-off on request.
    initial begin : receiver
        logic [15:0] pattern;
        int          seg_left;
        int          hold_left;
        pattern   = '1;
        seg_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LongHold;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 2))
                        0:       pattern = '1;
                        1:       pattern = 16'($urandom) | 16'h0001;
                        default: pattern = 16'($urandom & $urandom) | 16'h0001;
                    endcase
                end
                seg_left--;
                i_out_ready <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
            end
        end
    end

    // Offers one source byte and returns at the edge that accepts it; the
    // sender then either keeps going or takes a gap between bursts.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int gap;
        i_in_valid    <= 1'b1;
        i_in_byte     <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_text();
        int n;
        n = text_q.size();
        for (int i = 0; i < n; i++) begin
            send_byte(text_q[i], i == n - 1);
        end
        text_q.delete();
    endtask

    // One edge first, so that the final accepted request has been noted.
    task automatic await_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic void add_byte(logic [7:0] c);
        text_q.push_back(c);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endfunction

    function automatic void add_word();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) add_byte(8'($urandom_range(8'h61, 8'h7A)));
    endfunction

    // Balanced bracket group, sometimes nested and sometimes a vector.
    function automatic void add_group(int lvl);
        int n;
        int r;
        n = $urandom_range(0, 3);
        add_byte(ChOpen);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 3);
            if (i > 0) begin
                add_byte(ChSpace);
            end
            if ((r == 0) && (lvl < 3)) begin
                add_group(lvl + 1);
            end else if ((r == 1) && (lvl < 3)) begin
                add_byte(ChHash);
                add_group(lvl + 1);
            end else begin
                add_word();
            end
        end
        add_byte(ChClose);
    endfunction

    // A random text built mostly from well-formed pieces, with some noise.
    function automatic void build_text();
        int    chunks;
        string punct;
        punct  = "()#';\"\n \t";
        chunks = $urandom_range(1, 6);
        repeat (chunks) begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    add_word();
                    add_byte(ChSpace);
                end
                2: begin
                    add_byte(ChQuote);
                    if ($urandom_range(0, 1) == 1) add_word();
                    else add_group(0);
                    case ($urandom_range(0, 3))
                        0:       add_byte(ChSpace);
                        1:       add_byte(ChClose);
                        2:       add_byte(ChNewline);
                        default: ;
                    endcase
                end
                3: begin
                    add_byte(ChSemi);
                    add_word();
                    if ($urandom_range(0, 3) != 0) add_byte(ChNewline);
                end
                4: begin
                    add_byte(ChDquote);
                    add_word();
                    if ($urandom_range(0, 3) != 0) add_byte(ChDquote);
                end
                5: begin
                    add_byte(ChHash);
                    add_group(1);
                end
                6: begin
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    add_byte(ChHash);
                    add_byte(punct[$urandom_range(0, punct.len() - 1)]);
                end
            endcase
        end
    endfunction

    initial begin : stimulus
        int texts;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts: datum closed by a bracket, by end of text and by
        // whitespace, vectors, open comment and string, a held hash at the
        // end, top-bit bytes, plain marks inside a datum, hash before quote.
        add_str("'(a)b)");
        send_text();
        add_str("#(x) 'y");
        send_text();
        add_str(";#(\n;");
        send_text();
        add_str("\"ab");
        send_text();
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(ChHash);
        send_text();
        add_str("'\";\t");
        send_text();
        add_str("#'");
        send_text();
        await_drained();

        // Depth saturation: more opening brackets than the counter holds, so
        // the closing brackets that follow stay inside the datum.
        add_byte(ChQuote);
        repeat (MaxDepth + 2) add_byte(ChOpen);
        repeat (2) add_byte(ChClose);
        add_byte(8'h7A);
        send_text();
        await_drained();

        // Random texts; the first ones run against a long output stall.
        long_hold_req = 1'b1;
        texts = 0;
        items_sent = 0;
        while (items_sent < RandomItems) begin
            build_text();
            send_text();
            texts++;
            if (texts % 8 == 0) begin
                await_drained();
            end
        end

        await_drained();
        repeat (16) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("out_byte: %0d expected bytes never arrived", sb.pending());
        end
        if ((sb.errors == 0) && (sb.pending() == 0)) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
